// ----- rtl/alpn_lv_pkg.sv -----
// alpn_lv_pkg: shared types and constants for the alpn list validator
// no dependencies; used by every module in rtl/

package alpn_lv_pkg;

  // counted part of the list, in bytes
  localparam int unsigned BUFFER_BYTES = 64;
  // entry count limit, reaching it rejects
  localparam int unsigned MAX_ENTRIES  = 32;

  localparam int unsigned PosW  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ByteW = 8;

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ByteW-1:0] byte_t;

  localparam pos_t BufLimit = pos_t'(BUFFER_BYTES);
  localparam cnt_t CntLimit = cnt_t'(MAX_ENTRIES);

  localparam logic VERDICT_PASS   = 1'b0;
  localparam logic VERDICT_REJECT = 1'b1;

  // one input transaction
  typedef struct packed {
    byte_t data_byte;
    logic  last_byte;
    logic  no_list;
  } item_t;

  // what the checker hands on when an item is processed
  typedef struct packed {
    logic produces;
    logic verdict;
  } result_t;

endpackage

// ----- rtl/alpn_lv_in_reg.sv -----
// alpn_lv_in_reg: input register stage holding one accepted item
// depends on alpn_lv_pkg

module alpn_lv_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               pop_i,
  input  alpn_lv_pkg::item_t item_i,
  output logic               valid_o,
  output alpn_lv_pkg::item_t item_o
);

  logic               valid_q, valid_d;
  alpn_lv_pkg::item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/alpn_lv_check.sv -----
// alpn_lv_check: list state registers and the per-byte check logic
// depends on alpn_lv_pkg

module alpn_lv_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  alpn_lv_pkg::item_t   item_i,
  output alpn_lv_pkg::result_t result_o
);

  alpn_lv_pkg::pos_t  pos_q, pos_d;
  alpn_lv_pkg::byte_t left_q, left_d;
  alpn_lv_pkg::cnt_t  cnt_q, cnt_d;
  logic               bad_q, bad_d;

  alpn_lv_pkg::pos_t  pos_n;
  alpn_lv_pkg::byte_t left_n;
  alpn_lv_pkg::cnt_t  cnt_n;
  logic               bad_n;
  logic               reject;

  always_comb begin
    pos_n  = pos_q;
    left_n = left_q;
    cnt_n  = cnt_q;
    bad_n  = bad_q;
    if (pos_q < alpn_lv_pkg::BufLimit) begin
      if (left_q == '0) begin
        // length byte opens a new entry
        if (!bad_q) begin
          if (cnt_q >= alpn_lv_pkg::CntLimit) begin
            bad_n = 1'b1;
          end else if (item_i.data_byte == '0) begin
            bad_n = 1'b1;
          end else begin
            cnt_n  = cnt_q + alpn_lv_pkg::cnt_t'(1);
            left_n = item_i.data_byte;
          end
        end
      end else begin
        left_n = left_q - alpn_lv_pkg::byte_t'(1);
      end
      pos_n = pos_q + alpn_lv_pkg::pos_t'(1);
    end
    reject = bad_n || (left_n != '0) || (cnt_n >= alpn_lv_pkg::CntLimit);
  end

  always_comb begin
    pos_d  = pos_q;
    left_d = left_q;
    cnt_d  = cnt_q;
    bad_d  = bad_q;
    if (fire_i) begin
      if (item_i.no_list || item_i.last_byte) begin
        pos_d  = '0;
        left_d = '0;
        cnt_d  = '0;
        bad_d  = 1'b0;
      end else begin
        pos_d  = pos_n;
        left_d = left_n;
        cnt_d  = cnt_n;
        bad_d  = bad_n;
      end
    end
  end

  always_comb begin
    result_o.produces = item_i.no_list || item_i.last_byte;
    if (item_i.no_list) begin
      result_o.verdict = alpn_lv_pkg::VERDICT_REJECT;
    end else begin
      result_o.verdict = reject ? alpn_lv_pkg::VERDICT_REJECT : alpn_lv_pkg::VERDICT_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      left_q <= '0;
      cnt_q  <= '0;
      bad_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
      bad_q  <= bad_d;
    end
  end

`ifndef SYNTH
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= alpn_lv_pkg::CntLimit)
    else $error("entry count above limit");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= alpn_lv_pkg::BufLimit)
    else $error("byte position above buffer size");

  a_clear_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && result_o.produces) |=>
      (pos_q == '0 && left_q == '0 && cnt_q == '0 && !bad_q))
    else $error("state not cleared after verdict");
`endif

endmodule

// ----- rtl/alpn_lv_out_reg.sv -----
// alpn_lv_out_reg: result register on the output channel
// depends on alpn_lv_pkg

module alpn_lv_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  alpn_lv_pkg::result_t result_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 verdict_o
);

  logic valid_q, valid_d;
  logic verdict_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= result_i.verdict;
    end
  end

  assign out_valid_o = valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ----- rtl/alpn_list_validator_unit.sv -----
// alpn_list_validator_unit: top level of the alpn protocol list validator
// depends on alpn_lv_pkg, alpn_lv_in_reg, alpn_lv_check, alpn_lv_out_reg

// Checks a TLS ALPN protocol list streamed one byte per transaction, with the
// final byte marked by last_byte_i, or a single no_list_i transaction when no
// list exists. One verdict comes out per list: 1 (reject) for no list, a
// zero-length entry, an entry cut off at the end, or an entry count reaching
// MAX_ENTRIES; 0 (pass) otherwise. Only the first BUFFER_BYTES bytes are
// checked. One byte is accepted every cycle; a byte passes through the input
// register, the check logic and, if it ends the list, the result register,
// which then offers the verdict. The input stalls only while a verdict waits
// in the result register without being taken and the item in the input
// register also ends a list.

module alpn_list_validator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [alpn_lv_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  input  logic                      no_list_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      verdict_o
);

  alpn_lv_pkg::item_t   item_in, item_q;
  alpn_lv_pkg::result_t result;
  logic                 stage_valid;
  logic                 advance;
  logic                 load;

  assign item_in.data_byte = data_byte_i;
  assign item_in.last_byte = last_byte_i;
  assign item_in.no_list   = no_list_i;

  // items with no verdict never wait on the output side
  assign advance    = stage_valid && (!result.produces || !out_valid_o || out_ready_i);
  assign in_ready_o = !stage_valid || advance;
  assign load       = in_valid_i && in_ready_o;

  alpn_lv_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .pop_i   (advance),
    .item_i  (item_in),
    .valid_o (stage_valid),
    .item_o  (item_q)
  );

  alpn_lv_check u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .result_o (result)
  );

  alpn_lv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && result.produces),
    .result_i    (result),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .verdict_o   (verdict_o)
  );

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid |-> in_ready_o)
    else $error("input stalled with empty stage");

  a_verdict_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result.produces) |=> out_valid_o)
    else $error("verdict not registered");

  a_no_list_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.no_list) |=> (verdict_o == alpn_lv_pkg::VERDICT_REJECT))
    else $error("missing list did not reject");
`endif

endmodule
